/* design/null_symbol_energy_search_assert.svh */
// ----------------------------------------------------------------------------
// Null symbol energy search: assertion macros
// Shared property wrappers so every check uses the same clock; one form is reset-gated.
// ----------------------------------------------------------------------------
`ifndef NULL_SYMBOL_ENERGY_SEARCH_ASSERT_SVH
`define NULL_SYMBOL_ENERGY_SEARCH_ASSERT_SVH

// Checked on every rising edge of clk, switched off while rst is high.
`define NSES_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define NSES_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/nses_pkg.sv */
// ----------------------------------------------------------------------------
// Null symbol energy search: package
// Widths, register indexes, control structs and helpers shared by the block.
// ----------------------------------------------------------------------------
package nses_pkg;

  localparam int WINDOW_LEN  = 2656;
  localparam int SLOT_W      = $clog2(WINDOW_LEN);
  localparam int QUARTER_WIN = WINDOW_LEN / 4;

  localparam int SAMP_W     = 16;
  localparam int IN_DATA_W  = 2 * SAMP_W;
  localparam int POS_W      = 19;
  localparam int LEN_W      = 18;
  localparam int STEP_W     = 5;
  localparam int THR_W      = 16;
  localparam int ENERGY_W   = 32;
  localparam int DELTA_W    = ENERGY_W + 1;
  localparam int SUM_W      = 49;
  localparam int ACC_W      = 51;
  localparam int PROD_W     = SUM_W + THR_W;
  localparam int PHASE_W    = 4;
  localparam int MAX_STEP   = 16;

  localparam int OUT_BITS   = POS_W + 2 * SUM_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = POS_W;

  localparam logic [LEN_W-1:0] COUNT_MAX = '1;

  localparam logic signed [POS_W-1:0] START_OFFSET_RESET     = -19'sd1328;
  localparam logic [LEN_W-1:0]        SEARCH_LEN_RESET       = LEN_W'(2656);
  localparam logic [STEP_W-1:0]       DECIMATION_STEP_RESET  = STEP_W'(1);
  localparam logic [THR_W-1:0]        ENERGY_THRESHOLD_RESET = THR_W'(32768);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_OFFSET     = 2'd0,
    REG_SEARCH_LEN       = 2'd1,
    REG_DECIMATION_STEP  = 2'd2,
    REG_ENERGY_THRESHOLD = 2'd3
  } reg_index_t;

  // Per-sample control decided at the input side.
  typedef struct packed {
    logic              last;
    logic              active;
    logic              win;
    logic              base;
    logic [SLOT_W-1:0] slot;
    logic [LEN_W-1:0]  n;
  } ctl_t;

  // Registers the result side needs.
  typedef struct packed {
    logic signed [POS_W-1:0] start_offset;
    logic [THR_W-1:0]        energy_threshold;
  } res_cfg_t;

  // Search state captured at the end of a span.
  typedef struct packed {
    logic signed [ACC_W-1:0] best_min;
    logic signed [ACC_W-1:0] best_max;
    logic [LEN_W-1:0]        best_offset;
    logic [SUM_W-1:0]        base_sum;
  } snap_t;

  // One finished result.
  typedef struct packed {
    logic                    good;
    logic [SUM_W-1:0]        max_energy;
    logic [SUM_W-1:0]        min_energy;
    logic signed [POS_W-1:0] position;
  } result_t;

  // A step of zero acts as one, anything above the largest stride is clipped.
  function automatic logic [STEP_W-1:0] eff_step(input logic [STEP_W-1:0] s);
    logic [STEP_W-1:0] r;
    r = s;
    if (s == '0) begin
      r = STEP_W'(1);
    end else if (s > STEP_W'(MAX_STEP)) begin
      r = STEP_W'(MAX_STEP);
    end
    return r;
  endfunction

endpackage

/* design/nses_front.sv */
// ----------------------------------------------------------------------------
// Null symbol energy search: input side
// Configuration registers, sample counters and the per-sample control flags.
// ----------------------------------------------------------------------------
module nses_front import nses_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic                  s_tlast,
  input  logic                  room,
  output logic                  last_accept,
  output logic                  s1_valid,
  output logic signed [SAMP_W-1:0] s1_i,
  output logic signed [SAMP_W-1:0] s1_q,
  output ctl_t                  s1_ctl,
  output res_cfg_t              res_cfg
);

  logic signed [POS_W-1:0] start_offset;
  logic [LEN_W-1:0]        search_len;
  logic [STEP_W-1:0]       decimation_step;
  logic [THR_W-1:0]        energy_threshold;

  logic [LEN_W-1:0]   sample_count;
  logic [SLOT_W-1:0]  slot;
  logic [PHASE_W-1:0] stride_phase;
  // n_res[k] holds n modulo k+1, so any stride can be tested at once.
  logic [PHASE_W-1:0] n_res [MAX_STEP];

  logic               accept;
  logic [STEP_W-1:0]  step;
  logic [STEP_W-1:0]  step_m1;
  logic               active;
  logic               m_ge_w;
  logic [LEN_W-1:0]   n;
  logic [PHASE_W-1:0] phase;
  logic [STEP_W-1:0]  phase_inc;
  logic [PHASE_W-1:0] stride_phase_next;
  ctl_t               ctl;

  assign s_tready    = room;
  assign accept      = s_tvalid && s_tready;
  assign last_accept = accept && s_tlast;
  assign res_cfg     = '{start_offset: start_offset, energy_threshold: energy_threshold};

  always_ff @(posedge clk) begin
    if (rst) begin
      start_offset     <= START_OFFSET_RESET;
      search_len       <= SEARCH_LEN_RESET;
      decimation_step  <= DECIMATION_STEP_RESET;
      energy_threshold <= ENERGY_THRESHOLD_RESET;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_START_OFFSET:     start_offset     <= cfg_data;
        REG_SEARCH_LEN:       search_len       <= cfg_data[LEN_W-1:0];
        REG_DECIMATION_STEP:  decimation_step  <= cfg_data[STEP_W-1:0];
        REG_ENERGY_THRESHOLD: energy_threshold <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    step      = eff_step(decimation_step);
    step_m1   = step - STEP_W'(1);
    active    = (sample_count != COUNT_MAX);
    m_ge_w    = (sample_count >= LEN_W'(WINDOW_LEN));
    n         = sample_count - LEN_W'(WINDOW_LEN);
    phase     = ({1'b0, stride_phase} >= step) ? '0 : stride_phase;
    phase_inc = {1'b0, phase} + STEP_W'(1);
    stride_phase_next = (phase_inc >= step) ? '0 : phase_inc[PHASE_W-1:0];

    ctl.last   = s_tlast;
    ctl.active = active;
    ctl.win    = active && m_ge_w && (n < search_len) &&
                 (n_res[step_m1[PHASE_W-1:0]] == '0);
    ctl.base   = active && (sample_count < search_len) && (phase == '0);
    ctl.slot   = slot;
    ctl.n      = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      slot         <= '0;
      stride_phase <= '0;
      for (int k = 0; k < MAX_STEP; k++) begin
        n_res[k] <= '0;
      end
    end else if (accept) begin
      if (s_tlast) begin
        // The span ends here; the next sample starts a new one.
        sample_count <= '0;
        slot         <= '0;
        stride_phase <= '0;
        for (int k = 0; k < MAX_STEP; k++) begin
          n_res[k] <= '0;
        end
      end else if (active) begin
        sample_count <= sample_count + LEN_W'(1);
        slot         <= (slot == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot + SLOT_W'(1);
        stride_phase <= stride_phase_next;
        if (m_ge_w) begin
          for (int k = 0; k < MAX_STEP; k++) begin
            n_res[k] <= (n_res[k] == PHASE_W'(k)) ? '0 : n_res[k] + PHASE_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_i   <= s_tdata[SAMP_W-1:0];
      s1_q   <= s_tdata[IN_DATA_W-1:SAMP_W];
      s1_ctl <= ctl;
    end
  end

endmodule

/* design/nses_window.sv */
// ----------------------------------------------------------------------------
// Null symbol energy search: energy and window tracking
// Sample energy, the energy delay line and the sliding sum with its extremes.
// ----------------------------------------------------------------------------
module nses_window import nses_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s1_valid,
  input  logic signed [SAMP_W-1:0] s1_i,
  input  logic signed [SAMP_W-1:0] s1_q,
  input  ctl_t                     s1_ctl,
  output logic                     snap_valid,
  output snap_t                    snap
);

  logic [ENERGY_W-1:0] delay_mem [WINDOW_LEN];
  logic [ENERGY_W-1:0] old_energy;

  logic signed [ENERGY_W-1:0] sq_i;
  logic signed [ENERGY_W-1:0] sq_q;
  logic [ENERGY_W-1:0]        energy;

  logic                s2_valid;
  ctl_t                s2_ctl;
  logic [ENERGY_W-1:0] s2_energy;

  logic                      s3_valid;
  ctl_t                      s3_ctl;
  logic [ENERGY_W-1:0]       s3_energy;
  logic signed [DELTA_W-1:0] s3_delta;

  logic signed [ACC_W-1:0] running_sum;
  logic [SUM_W-1:0]        base_sum;
  logic signed [ACC_W-1:0] best_min;
  logic signed [ACC_W-1:0] best_max;
  logic [LEN_W-1:0]        best_offset;

  logic signed [ACC_W-1:0] sum_moved;
  logic signed [ACC_W-1:0] running_sum_next;
  logic [SUM_W-1:0]        base_sum_next;
  logic signed [ACC_W-1:0] best_min_next;
  logic signed [ACC_W-1:0] best_max_next;
  logic [LEN_W-1:0]        best_offset_next;
  logic                    min_hit;
  logic                    max_hit;

  // The two squares are at most 2^30 each, so their sum fits 32 bits unsigned.
  always_comb begin
    sq_i   = s1_i * s1_i;
    sq_q   = s1_q * s1_q;
    energy = ENERGY_W'(unsigned'(sq_i)) + ENERGY_W'(unsigned'(sq_q));
  end

  // A slot is read again only a full window after it was written, far beyond
  // the gap between the read at stage s1 and the write at stage s2 here.
  always_ff @(posedge clk) begin
    if (s1_valid && s1_ctl.active) begin
      old_energy <= delay_mem[s1_ctl.slot];
    end
    if (s2_valid && s2_ctl.active) begin
      delay_mem[s2_ctl.slot] <= s2_energy;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_ctl    <= s1_ctl;
    s2_energy <= energy;
    s3_ctl    <= s2_ctl;
    s3_energy <= s2_energy;
    s3_delta  <= $signed({1'b0, s2_energy}) - $signed({1'b0, old_energy});
  end

  always_comb begin
    sum_moved = running_sum + ACC_W'(s3_delta);
    min_hit   = s3_ctl.win && (sum_moved < best_min);
    max_hit   = s3_ctl.win && !min_hit && (sum_moved > best_max);

    running_sum_next = s3_ctl.win ? sum_moved : running_sum;
    best_min_next    = min_hit ? sum_moved : best_min;
    best_offset_next = min_hit ? s3_ctl.n : best_offset;
    best_max_next    = max_hit ? sum_moved : best_max;
    base_sum_next    = s3_ctl.base ? base_sum + SUM_W'(s3_energy) : base_sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
      base_sum    <= '0;
      best_min    <= '0;
      best_max    <= '0;
      best_offset <= '0;
      snap_valid  <= 1'b0;
    end else begin
      snap_valid <= s3_valid && s3_ctl.last;
      if (s3_valid) begin
        if (s3_ctl.last) begin
          running_sum <= '0;
          base_sum    <= '0;
          best_min    <= '0;
          best_max    <= '0;
          best_offset <= '0;
        end else begin
          running_sum <= running_sum_next;
          base_sum    <= base_sum_next;
          best_min    <= best_min_next;
          best_max    <= best_max_next;
          best_offset <= best_offset_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s3_valid && s3_ctl.last) begin
      snap <= '{best_min: best_min_next, best_max: best_max_next,
                best_offset: best_offset_next, base_sum: base_sum_next};
    end
  end

endmodule

/* design/nses_result.sv */
// ----------------------------------------------------------------------------
// Null symbol energy search: result side
// Final position and energies, the ratio test and the result queue.
// ----------------------------------------------------------------------------
module nses_result import nses_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  snap_valid,
  input  snap_t                 snap,
  input  res_cfg_t              res_cfg,
  input  logic                  last_accept,
  output logic                  room,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tuser
);

  logic                    r2_valid;
  logic signed [POS_W-1:0] r2_pos;
  logic [SUM_W-1:0]        r2_min;
  logic [SUM_W-1:0]        r2_max;
  logic                    r2_near;

  logic                    r3_valid;
  logic signed [POS_W-1:0] r3_pos;
  logic [SUM_W-1:0]        r3_min;
  logic [SUM_W-1:0]        r3_max;
  logic                    r3_near;
  logic [PROD_W-1:0]       r3_prod;

  logic signed [POS_W-1:0] pos;
  result_t                 fin;

  result_t              queue [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr;
  logic [FIFO_AW-1:0]   rd_ptr;
  logic [FIFO_CW-1:0]   fill;
  logic [FIFO_CW-1:0]   pending;
  logic                 out_fire;
  result_t              head;

  assign pos = res_cfg.start_offset + $signed(POS_W'(snap.best_offset));

  always_ff @(posedge clk) begin
    if (rst) begin
      r2_valid <= 1'b0;
      r3_valid <= 1'b0;
    end else begin
      r2_valid <= snap_valid;
      r3_valid <= r2_valid;
    end
  end

  always_ff @(posedge clk) begin
    r2_pos  <= pos;
    r2_min  <= snap.base_sum + snap.best_min[SUM_W-1:0];
    r2_max  <= snap.base_sum + snap.best_max[SUM_W-1:0];
    r2_near <= (pos > -POS_W'(QUARTER_WIN)) && (pos < POS_W'(QUARTER_WIN));

    r3_pos  <= r2_pos;
    r3_min  <= r2_min;
    r3_max  <= r2_max;
    r3_near <= r2_near;
    r3_prod <= PROD_W'(r2_max) * PROD_W'(res_cfg.energy_threshold);
  end

  // min * 2^16 against threshold * max, both exact in PROD_W bits.
  always_comb begin
    fin.position   = r3_pos;
    fin.min_energy = r3_min;
    fin.max_energy = r3_max;
    fin.good       = r3_near && ({r3_min, {THR_W{1'b0}}} < r3_prod);
  end

  assign out_fire = m_tvalid && m_tready;
  assign head     = queue[rd_ptr];
  assign m_tvalid = (fill != '0);
  assign m_tdata  = OUT_DATA_W'({head.max_energy, head.min_energy, head.position});
  assign m_tuser  = head.good;
  // Results still in flight plus those queued never exceed the queue depth.
  assign room     = (pending != FIFO_CW'(FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (r3_valid) begin
      queue[wr_ptr] <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      fill    <= '0;
      pending <= '0;
    end else begin
      if (r3_valid) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (out_fire) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      fill    <= fill + FIFO_CW'(r3_valid) - FIFO_CW'(out_fire);
      pending <= pending + FIFO_CW'(last_accept) - FIFO_CW'(out_fire);
    end
  end

endmodule

/* design/null_symbol_energy_search.sv */
// ----------------------------------------------------------------------------
// Null symbol energy search: top level
// Finds the minimum-energy window position over a span of complex samples.
// ----------------------------------------------------------------------------
// Samples enter one per cycle on the s_ group while s_tready is high; a span
// ends with tlast. Each sample's energy goes into a 2656-entry delay line (one
// read and one write port), and at every stride position the window sum is
// slid and its first minimum, the minimum and the maximum are tracked; the
// adder and compare of that tracking stage sets the one-sample-per-cycle rate.
// A result passes stages s1, s2, s3, the snapshot, r2 and r3 to the queue
// behind m_tvalid. Up to eight results are buffered; s_tready falls only while
// eight results are outstanding. The delay line needs no clearing after reset.
module null_symbol_energy_search import nses_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,    // sample_i[15:0], sample_q[31:16]
  input  logic                  s_tlast,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // min_position[18:0], min_energy[67:19], max_energy[116:68], zeros above
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tuser     // still_good[0]
);

  logic                     room;
  logic                     last_accept;
  logic                     s1_valid;
  logic signed [SAMP_W-1:0] s1_i;
  logic signed [SAMP_W-1:0] s1_q;
  ctl_t                     s1_ctl;
  res_cfg_t                 res_cfg;
  logic                     snap_valid;
  snap_t                    snap;

  nses_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .room        (room),
    .last_accept (last_accept),
    .s1_valid    (s1_valid),
    .s1_i        (s1_i),
    .s1_q        (s1_q),
    .s1_ctl      (s1_ctl),
    .res_cfg     (res_cfg)
  );

  nses_window u_window (
    .clk        (clk),
    .rst        (rst),
    .s1_valid   (s1_valid),
    .s1_i       (s1_i),
    .s1_q       (s1_q),
    .s1_ctl     (s1_ctl),
    .snap_valid (snap_valid),
    .snap       (snap)
  );

  nses_result u_result (
    .clk         (clk),
    .rst         (rst),
    .snap_valid  (snap_valid),
    .snap        (snap),
    .res_cfg     (res_cfg),
    .last_accept (last_accept),
    .room        (room),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser)
  );

endmodule

/* design/nses_checker.sv */
// ----------------------------------------------------------------------------
// Null symbol energy search: port checker
// Watches the result-side ports and is bound to every instance of the block.
// ----------------------------------------------------------------------------
`include "null_symbol_energy_search_assert.svh"

module nses_checker import nses_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic                  m_tuser
);

  logic signed [POS_W-1:0] out_pos;
  logic [SUM_W-1:0]        out_min;
  logic [SUM_W-1:0]        out_max;
  logic                    out_near;
  logic [OUT_DATA_W:0]     out_word;
  logic                    m_stall;
  logic                    m_good;

  assign out_pos  = m_tdata[POS_W-1:0];
  assign out_min  = m_tdata[POS_W+SUM_W-1:POS_W];
  assign out_max  = m_tdata[POS_W+2*SUM_W-1:POS_W+SUM_W];
  assign out_near = (out_pos > -POS_W'(QUARTER_WIN)) && (out_pos < POS_W'(QUARTER_WIN));
  assign out_word = {m_tuser, m_tdata};
  assign m_stall  = m_tvalid && !m_tready;
  assign m_good   = m_tvalid && m_tuser;

  `NSES_ASSERT_ALWAYS(a_no_result_after_reset, rst |=> !m_tvalid, "result shown after reset")
  `NSES_ASSERT(a_result_held, m_stall |=> m_tvalid && $stable(out_word), "stalled result changed")
  `NSES_ASSERT(a_good_min_below_max, m_good |-> out_min < out_max, "min not below max")
  `NSES_ASSERT(a_good_position_near, m_good |-> out_near, "good result far from zero")

endmodule

bind null_symbol_energy_search nses_checker u_nses_checker (.*);

/* verif/tb_null_symbol_energy_search.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Null symbol energy search: testbench
// Streams spans of complex samples into the block and predicts every result
// (minimum position, minimum and maximum window energy, still-good flag) with
// a scoreboard class that keeps its own delay line and search state. Short
// spans under random register settings exercise the span bookkeeping, the
// stride and base sum, the ratio test and the output buffering.
// ----------------------------------------------------------------------------
module tb_null_symbol_energy_search;
  import nses_pkg::*;

  localparam int     HALF_PERIOD           = 4;
  localparam int     DRAIN_CYCLES          = 24;
  localparam int     SHORT_ITEMS_PER_PHASE = 360;
  localparam longint RUN_LIMIT_NS          = 10_000_000;

  // Keeps the predicted search state and the results still owed by the block.
  class null_search_board;
    logic signed [POS_W-1:0] start_offset;
    logic [LEN_W-1:0]        search_len;
    logic [STEP_W-1:0]       decimation_step;
    logic [THR_W-1:0]        energy_threshold;
    logic [ENERGY_W-1:0]     energy_line [WINDOW_LEN];
    longint                  window_offset;
    longint                  base_total;
    longint                  low_offset;
    longint                  high_offset;
    int unsigned             low_at;
    int unsigned             sample_count;
    int unsigned             stride_phase;
    result_t                 expected_nulls [$];
    int                      mismatches;
    int                      results_seen;

    function new();
      foreach (energy_line[k]) energy_line[k] = '0;
      start_offset     = START_OFFSET_RESET;
      search_len       = SEARCH_LEN_RESET;
      decimation_step  = DECIMATION_STEP_RESET;
      energy_threshold = ENERGY_THRESHOLD_RESET;
      mismatches       = 0;
      results_seen     = 0;
      clear_span();
    endfunction

    function void clear_span();
      window_offset = 0;
      base_total    = 0;
      low_offset    = 0;
      high_offset   = 0;
      low_at        = 0;
      sample_count  = 0;
      stride_phase  = 0;
    endfunction

    function void set_config(logic signed [POS_W-1:0] start, logic [LEN_W-1:0] len,
                             logic [STEP_W-1:0] stride, logic [THR_W-1:0] thr);
      start_offset     = start;
      search_len       = len;
      decimation_step  = stride;
      energy_threshold = thr;
    endfunction

    function int outstanding();
      return expected_nulls.size();
    endfunction

    task report_mismatch(string what);
      $display("%0t ns: mismatch on result %0d: %s", $time, results_seen, what);
      mismatches++;
    endtask

    function void note_sample(logic signed [SAMP_W-1:0] si, logic signed [SAMP_W-1:0] sq,
                              logic last);
      int unsigned             stride;
      int unsigned             slot;
      int unsigned             n;
      longint                  energy;
      result_t                 due;
      logic signed [POS_W-1:0] pos;
      int                      pos_mag;
      logic [PROD_W:0]         scaled_min;
      logic [PROD_W:0]         scaled_max;
      if (decimation_step == '0) begin
        stride = 1;
      end else if (decimation_step > MAX_STEP) begin
        stride = MAX_STEP;
      end else begin
        stride = decimation_step;
      end
      // Once the counter saturates only the end-of-span mark matters.
      if (sample_count < COUNT_MAX) begin
        energy = longint'(si) * longint'(si) + longint'(sq) * longint'(sq);
        slot   = sample_count % WINDOW_LEN;
        if (sample_count >= WINDOW_LEN) begin
          n = sample_count - WINDOW_LEN;
          if (n < search_len && n % stride == 0) begin
            window_offset += energy - longint'(energy_line[slot]);
            if (window_offset < low_offset) begin
              low_offset = window_offset;
              low_at     = n;
            end else if (window_offset > high_offset) begin
              high_offset = window_offset;
            end
          end
        end
        energy_line[slot] = ENERGY_W'(energy);
        if (stride_phase >= stride) stride_phase = 0;
        if (sample_count < search_len && stride_phase == 0) base_total += energy;
        stride_phase = (stride_phase + 1 >= stride) ? 0 : stride_phase + 1;
        sample_count++;
      end
      if (!last) return;
      pos            = POS_W'(longint'(start_offset) + longint'(low_at));
      due.position   = pos;
      due.min_energy = SUM_W'(base_total + low_offset);
      due.max_energy = SUM_W'(base_total + high_offset);
      pos_mag        = (pos < 0) ? -int'(pos) : int'(pos);
      // The ratio test is done at full width so nothing can overflow.
      scaled_min = {due.min_energy, 16'h0000};
      scaled_max = due.max_energy;
      scaled_max = scaled_max * energy_threshold;
      due.good   = (pos_mag < QUARTER_WIN) && (scaled_min < scaled_max);
      expected_nulls.push_back(due);
      clear_span();
    endfunction

    task check_null_result(logic [OUT_DATA_W-1:0] data, logic user);
      result_t                 want;
      logic signed [POS_W-1:0] got_pos;
      logic [SUM_W-1:0]        got_min;
      logic [SUM_W-1:0]        got_max;
      results_seen++;
      if (expected_nulls.size() == 0) begin
        report_mismatch("result transfer with no result outstanding");
        return;
      end
      want    = expected_nulls.pop_front();
      got_pos = data[POS_W-1:0];
      got_min = data[POS_W +: SUM_W];
      got_max = data[POS_W+SUM_W +: SUM_W];
      if (got_pos !== want.position)
        report_mismatch($sformatf("min_position %0d, predicted %0d", got_pos, want.position));
      if (got_min !== want.min_energy)
        report_mismatch($sformatf("min_energy %0h, predicted %0h", got_min, want.min_energy));
      if (got_max !== want.max_energy)
        report_mismatch($sformatf("max_energy %0h, predicted %0h", got_max, want.max_energy));
      if (user !== want.good)
        report_mismatch($sformatf("still_good %0b, predicted %0b", user, want.good));
    endtask
  endclass

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_START_OFFSET;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;
  logic                  s_tlast   = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;

  int src_idle_pct  = 13;
  int sink_idle_pct = 55;

  null_search_board board;

  null_symbol_energy_search u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Both monitors look at the values that were present at the edge.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      board.note_sample(s_tdata[SAMP_W-1:0], s_tdata[IN_DATA_W-1:SAMP_W], s_tlast);
    end
    if (!rst && m_tvalid && m_tready) begin
      board.check_null_result(m_tdata, m_tuser);
    end
  end

  function automatic logic [SAMP_W-1:0] draw_component(int unsigned spread);
    if (spread >= 32768) return SAMP_W'($urandom);
    return SAMP_W'(int'($urandom_range(2 * spread)) - int'(spread));
  endfunction

  task automatic send_sample(input logic [SAMP_W-1:0] si, input logic [SAMP_W-1:0] sq,
                             input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {sq, si};
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Samples first_index onward of a span; those inside the dip are kept quiet
  // so the window sum has a clear minimum to find.
  task automatic send_burst(input int count, input int first_index, input int dip_at,
                            input int dip_len, input logic close);
    int idx;
    int unsigned spread;
    for (int k = 0; k < count; k++) begin
      idx    = first_index + k;
      spread = (idx >= dip_at && idx < dip_at + dip_len) ? 64 : 32768;
      send_sample(draw_component(spread), draw_component(spread), close && (k == count - 1));
    end
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (board.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic signed [POS_W-1:0] start, input logic [LEN_W-1:0] len,
                           input logic [STEP_W-1:0] stride, input logic [THR_W-1:0] thr);
    cfg_we    <= 1'b1;
    cfg_index <= REG_START_OFFSET;
    cfg_data  <= start;
    @(posedge clk);
    cfg_index <= REG_SEARCH_LEN;
    cfg_data  <= CFG_DATA_W'(len);
    @(posedge clk);
    cfg_index <= REG_DECIMATION_STEP;
    cfg_data  <= CFG_DATA_W'(stride);
    @(posedge clk);
    cfg_index <= REG_ENERGY_THRESHOLD;
    cfg_data  <= CFG_DATA_W'(thr);
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_config(start, len, stride, thr);
  endtask

  task automatic random_config(input int unsigned len_hi, input bit near_zero);
    logic signed [POS_W-1:0] start;
    logic [LEN_W-1:0]        len;
    logic [THR_W-1:0]        thr;
    if (near_zero) begin
      start = POS_W'($urandom_range(1400) - 700);
    end else begin
      case ($urandom_range(5))
        0:       start = -19'sd2656;
        1:       start = 19'sd196607;
        2:       start = {1'b1, {(POS_W-1){1'b0}}};
        3:       start = {1'b0, {(POS_W-1){1'b1}}};
        default: start = POS_W'($urandom);
      endcase
    end
    case ($urandom_range(7))
      0:       len = '0;
      1:       len = LEN_W'(1);
      2:       len = '1;
      default: len = LEN_W'($urandom_range(len_hi));
    endcase
    case ($urandom_range(5))
      0:       thr = '0;
      1:       thr = '1;
      default: thr = THR_W'($urandom);
    endcase
    configure(start, len, STEP_W'($urandom_range(31)), thr);
  endtask

  initial begin
    int span_items;
    int spans;
    int len;
    int cut;
    board = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset settings first, then the register extremes.
    send_sample(16'h8000, 16'h8000, 1'b1);
    send_sample(16'h7FFF, 16'h0000, 1'b0);
    send_sample(16'h0000, 16'h8001, 1'b0);
    send_sample(16'h0000, 16'h0000, 1'b1);
    settle();
    // Empty search with a step of zero.
    configure(-19'sd2656, '0, '0, '1);
    send_sample(16'h7FFF, 16'h7FFF, 1'b0);
    send_sample(16'h8000, 16'h7FFF, 1'b1);
    send_sample(16'h0001, 16'hFFFF, 1'b1);
    send_sample(16'hFFFF, 16'h0001, 1'b1);
    send_sample(16'h8000, 16'h0000, 1'b1);
    settle();
    // Step above the largest stride.
    configure(19'sd196607, LEN_W'(1), 5'd31, '0);
    send_sample(16'h1234, 16'h8765, 1'b0);
    send_sample(16'h7FFF, 16'h8000, 1'b0);
    send_sample(16'h0000, 16'h0000, 1'b1);
    settle();
    configure({1'b1, {(POS_W-1){1'b0}}}, '1, STEP_W'(MAX_STEP), '1);
    send_sample(16'h5A5A, 16'hA5A5, 1'b0);
    send_sample(16'hFFFF, 16'hFFFF, 1'b1);
    settle();
    // Step lowered mid span while the stride phase is at or past the new step.
    configure(19'sd5, LEN_W'(40), 5'd5, 16'd40000);
    send_burst(7, 0, 0, 0, 1'b0);
    settle();
    configure(19'sd5, LEN_W'(40), 5'd2, 16'd40000);
    send_burst(3, 7, 0, 0, 1'b1);
    settle();

    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct  = (ph == 0) ? 13 : (ph == 1) ? 55 : 0;
      sink_idle_pct = (ph == 0) ? 55 : (ph == 1) ? 13 : 0;
      random_config(80, 1'b0);
      span_items = 0;
      spans      = 0;
      while (span_items < SHORT_ITEMS_PER_PHASE) begin
        len = $urandom_range(40, 1);
        if (len > 1 && $urandom_range(7) == 0) begin
          cut = $urandom_range(len - 1, 1);
          send_burst(cut, 0, 0, 0, 1'b0);
          settle();
          random_config(80, $urandom_range(1));
          send_burst(len - cut, cut, 0, 0, 1'b1);
        end else begin
          send_burst(len, 0, 0, 0, 1'b1);
        end
        span_items += len;
        spans++;
        if (spans % 6 == 0) begin
          settle();
          random_config(80, $urandom_range(1));
        end
      end
      settle();
    end

    if (board.mismatches == 0 && board.outstanding() == 0) begin
      $display("tb_null_symbol_energy_search: clean");
    end else begin
      $display("tb_null_symbol_energy_search: errors");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("tb_null_symbol_energy_search: errors");
    $finish;
  end

endmodule

/* null_symbol_energy_search.f */
+incdir+design
design/nses_pkg.sv
design/nses_front.sv
design/nses_window.sv
design/nses_result.sv
design/null_symbol_energy_search.sv
design/nses_checker.sv
verif/tb_null_symbol_energy_search.sv
